// ===== hdl/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared widths, register indexes and reset key for the RSA CRT decrypt unit.
// ----------------------------------------------------------------------------
package rcd_pkg;

  localparam int PRIME_BITS = 32;
  localparam int MOD_BITS   = 2 * PRIME_BITS;
  localparam int CNT_W      = $clog2(MOD_BITS + 1);
  localparam int CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_Q    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT_P = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT_Q = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Q_INVERSE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 3'd5;

  localparam logic [PRIME_BITS-1:0] RST_PRIME_P    = PRIME_BITS'(61);
  localparam logic [PRIME_BITS-1:0] RST_PRIME_Q    = PRIME_BITS'(53);
  localparam logic [PRIME_BITS-1:0] RST_EXPONENT_P = PRIME_BITS'(53);
  localparam logic [PRIME_BITS-1:0] RST_EXPONENT_Q = PRIME_BITS'(49);
  localparam logic [PRIME_BITS-1:0] RST_Q_INVERSE  = PRIME_BITS'(38);
  localparam logic [MOD_BITS-1:0]   RST_MODULUS    = MOD_BITS'(3233);

endpackage

// ===== hdl/rsa_crt_decrypt_unit.sv =====
// ----------------------------------------------------------------------------
// rsa_crt_decrypt_unit
// RSA decryption by the Chinese remainder method with Garner recombination.
// ----------------------------------------------------------------------------
// One word is processed at a time. All modular arithmetic runs through one
// bit-serial unit that takes one multiplier bit per cycle with a double
// compare-subtract, for modular multiplies and for reductions of 64-bit
// values. Each exponentiation reduces the ciphertext modulo its prime, then
// per exponent bit runs a check step, a multiply into the accumulator when
// the bit is set and a squaring, and ends with a check step once the
// exponent is zero. Recombination reduces m2 and the q inverse modulo p,
// multiplies m1 - m2 by that inverse and adds m2 to that product times q;
// the result then moves into the output register. A word whose ciphertext
// is not below the modulus, or a key with a zero prime, returns message 0
// with range_error set by way of S_DONE. The input side accepts a new word
// once the previous one has moved into the output register.
module rsa_crt_decrypt_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rcd_pkg::MOD_BITS-1:0]      ciphertext_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rcd_pkg::MOD_BITS-1:0]      message_o,
  output logic                              range_error_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rcd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rcd_pkg::MOD_BITS-1:0]      cfg_data_i
);
  import rcd_pkg::*;

  localparam int PB = PRIME_BITS;
  localparam int MB = MOD_BITS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RED_C  = 4'd1;
  localparam logic [3:0] S_EXP    = 4'd2;
  localparam logic [3:0] S_MUL_A  = 4'd3;
  localparam logic [3:0] S_MUL_S  = 4'd4;
  localparam logic [3:0] S_RED_M2 = 4'd5;
  localparam logic [3:0] S_RED_QI = 4'd6;
  localparam logic [3:0] S_MUL_H  = 4'd7;
  localparam logic [3:0] S_PROD   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  // key registers
  logic [PB-1:0] p_q, q_q, ep_q, eq_q, qinv_q;
  logic [MB-1:0] n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q    <= RST_PRIME_P;
      q_q    <= RST_PRIME_Q;
      ep_q   <= RST_EXPONENT_P;
      eq_q   <= RST_EXPONENT_Q;
      qinv_q <= RST_Q_INVERSE;
      n_q    <= RST_MODULUS;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PRIME_P:    p_q    <= cfg_data_i[PB-1:0];
        REG_PRIME_Q:    q_q    <= cfg_data_i[PB-1:0];
        REG_EXPONENT_P: ep_q   <= cfg_data_i[PB-1:0];
        REG_EXPONENT_Q: eq_q   <= cfg_data_i[PB-1:0];
        REG_Q_INVERSE:  qinv_q <= cfg_data_i[PB-1:0];
        REG_MODULUS:    n_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic [3:0]       state_q, state_d;
  logic             sel_q, sel_d;        // 0: working mod p, 1: mod q
  logic [MB-1:0]    c_q, c_d;
  logic [MB-1:0]    x_q, x_d;            // serial operand, msb first
  logic [PB-1:0]    r_q, r_d;
  logic [PB-1:0]    b_q, b_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PB-1:0]    acc_q, acc_d, sq_q, sq_d, e_q, e_d;
  logic [PB-1:0]    m1_q, m1_d, m2_q, m2_d, m2r_q, m2r_d;
  logic [MB-1:0]    prod_q, prod_d;
  logic             err_q, err_d;
  logic             out_valid_q, out_valid_d;
  logic [MB-1:0]    msg_q, msg_d;
  logic             rerr_q, rerr_d;

  // bit-serial modular step
  logic [PB-1:0] mod_w;
  logic          is_red, is_mul, xbit, last;
  logic [PB:0]   t0, t2;
  logic [PB-1:0] t1, t3, rn;
  logic [MB-1:0] prod_n;
  logic [PB:0]   diff_w;

  assign is_red = (state_q == S_RED_C) || (state_q == S_RED_M2) || (state_q == S_RED_QI);
  assign is_mul = (state_q == S_MUL_A) || (state_q == S_MUL_S) || (state_q == S_MUL_H);
  assign mod_w  = (sel_q && ((state_q == S_RED_C) || (state_q == S_MUL_A)
                  || (state_q == S_MUL_S))) ? q_q : p_q;
  assign xbit   = x_q[MB-1];
  assign last   = (cnt_q == CNT_W'(1));

  always_comb begin
    t0 = {r_q, is_red & xbit};
    t1 = (t0 >= {1'b0, mod_w}) ? PB'(t0 - {1'b0, mod_w}) : t0[PB-1:0];
    t2 = {1'b0, t1} + {1'b0, b_q};
    t3 = (t2 >= {1'b0, mod_w}) ? PB'(t2 - {1'b0, mod_w}) : t2[PB-1:0];
    rn = (is_mul && xbit) ? t3 : t1;
    prod_n = {prod_q[MB-2:0], 1'b0} + (xbit ? MB'(q_q) : '0);
    // m1 - m2r mod p, m1 < p
    diff_w = (m1_q >= m2r_q) ? ({1'b0, m1_q} - {1'b0, m2r_q})
                             : ({1'b0, m1_q} + {1'b0, p_q} - {1'b0, m2r_q});
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    c_d         = c_q;
    x_d         = x_q;
    r_d         = r_q;
    b_d         = b_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    e_d         = e_q;
    m1_d        = m1_q;
    m2_d        = m2_q;
    m2r_d       = m2r_q;
    prod_d      = prod_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    msg_d       = msg_q;
    rerr_d      = rerr_q;

    if (is_mul || is_red) begin
      x_d   = {x_q[MB-2:0], 1'b0};
      r_d   = rn;
      cnt_d = cnt_q - CNT_W'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          c_d = ciphertext_i;
          if ((ciphertext_i >= n_q) || (p_q == '0) || (q_q == '0)) begin
            prod_d  = '0;
            err_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            err_d   = 1'b0;
            sel_d   = 1'b0;
            x_d     = ciphertext_i;
            r_d     = '0;
            cnt_d   = CNT_W'(MB);
            state_d = S_RED_C;
          end
        end
      end
      S_RED_C: begin
        if (last) begin
          sq_d    = rn;
          acc_d   = (mod_w == PB'(1)) ? '0 : PB'(1);
          e_d     = sel_q ? eq_q : ep_q;
          state_d = S_EXP;
        end
      end
      S_EXP: begin
        r_d   = '0;
        cnt_d = CNT_W'(PB);
        b_d   = sq_q;
        if (e_q == '0) begin
          if (!sel_q) begin
            m1_d    = acc_q;
            sel_d   = 1'b1;
            x_d     = c_q;
            cnt_d   = CNT_W'(MB);
            state_d = S_RED_C;
          end else begin
            m2_d    = acc_q;
            x_d     = MB'(acc_q);
            b_d     = '0;
            cnt_d   = CNT_W'(MB);
            state_d = S_RED_M2;
          end
        end else if (e_q[0]) begin
          x_d     = {acc_q, {(MB-PB){1'b0}}};
          state_d = S_MUL_A;
        end else begin
          x_d     = {sq_q, {(MB-PB){1'b0}}};
          state_d = S_MUL_S;
        end
      end
      S_MUL_A: begin
        if (last) begin
          acc_d   = rn;
          x_d     = {sq_q, {(MB-PB){1'b0}}};
          b_d     = sq_q;
          r_d     = '0;
          cnt_d   = CNT_W'(PB);
          state_d = S_MUL_S;
        end
      end
      S_MUL_S: begin
        if (last) begin
          sq_d    = rn;
          e_d     = e_q >> 1;
          state_d = S_EXP;
        end
      end
      S_RED_M2: begin
        if (last) begin
          m2r_d   = rn;
          x_d     = MB'(qinv_q);
          r_d     = '0;
          cnt_d   = CNT_W'(MB);
          state_d = S_RED_QI;
        end
      end
      S_RED_QI: begin
        if (last) begin
          x_d     = {rn, {(MB-PB){1'b0}}};
          b_d     = diff_w[PB-1:0];
          r_d     = '0;
          cnt_d   = CNT_W'(PB);
          state_d = S_MUL_H;
        end
      end
      S_MUL_H: begin
        if (last) begin
          x_d     = {rn, {(MB-PB){1'b0}}};
          prod_d  = '0;
          cnt_d   = CNT_W'(PB);
          state_d = S_PROD;
        end
      end
      S_PROD: begin
        x_d    = {x_q[MB-2:0], 1'b0};
        cnt_d  = cnt_q - CNT_W'(1);
        prod_d = prod_n;
        if (last) begin
          prod_d  = prod_n + MB'(m2_q);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          msg_d       = prod_q;
          rerr_d      = err_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q  <= sel_d;
    c_q    <= c_d;
    x_q    <= x_d;
    r_q    <= r_d;
    b_q    <= b_d;
    cnt_q  <= cnt_d;
    acc_q  <= acc_d;
    sq_q   <= sq_d;
    e_q    <= e_d;
    m1_q   <= m1_d;
    m2_q   <= m2_d;
    m2r_q  <= m2r_d;
    prod_q <= prod_d;
    err_q  <= err_d;
    msg_q  <= msg_d;
    rerr_q <= rerr_d;
  end

  assign out_valid_o   = out_valid_q;
  assign message_o     = msg_q;
  assign range_error_o = rerr_q;

endmodule

// ===== hdl/rcd_checker.sv =====
// ----------------------------------------------------------------------------
// rcd_checker
// Port-level checks for the RSA CRT decrypt unit.
// ----------------------------------------------------------------------------
module rcd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [rcd_pkg::MOD_BITS-1:0] message_o,
  input logic                         range_error_o
);
  import rcd_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(message_o)
      && $stable(range_error_o))
    else $error("result word changed while stalled");

  // an error word carries a zero message
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> message_o == '0)
    else $error("error word with nonzero message");

  // one word in flight: busy right after accepting
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // a result appears only after an input has been taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without pending word");

endmodule

bind rsa_crt_decrypt_unit rcd_checker u_rcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .message_o     (message_o),
  .range_error_o (range_error_o)
);
